FILE: design/stuffed_frame_receiver_crc32_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stuffed frame receiver
// Concurrent assertion shorthands used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_CRC32_TOP_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_CRC32_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SFRC_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define SFRC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SFRC_ASSERT_NOW(label, clk, rst_n, pre, post)
`define SFRC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

FILE: design/sfrc_pkg.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Framing constants, CRC-32 constants and field widths.
// ----------------------------------------------------------------------------
package sfrc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned CountW  = 13;
  localparam int unsigned CrcW    = 32;
  localparam int unsigned TailLen = 4;

  localparam logic [ByteW-1:0]  FlagByte = 8'h7E;
  localparam logic [ByteW-1:0]  EscByte  = 8'h7D;
  localparam logic [ByteW-1:0]  EscXor   = 8'h20;

  localparam logic [CrcW-1:0]   CrcPoly  = 32'hEDB8_8320;
  localparam logic [CrcW-1:0]   CrcInit  = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0]   CrcXorOut = 32'hFFFF_FFFF;

  localparam logic [CountW-1:0] MaxFrameBytes = 13'd4096;
  localparam logic [CountW-1:0] LimitReset    = 13'd4096;
  localparam logic [CountW-1:0] CrcLagBytes   = 13'd4;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef logic [ByteW-1:0] byte_t;

endpackage

FILE: design/sfrc_crc_byte.sv
// ----------------------------------------------------------------------------
// Byte-wide CRC-32 update
// Folds one byte into a reflected CRC-32 register value.
// ----------------------------------------------------------------------------
module sfrc_crc_byte import sfrc_pkg::*; (
  input  logic [CrcW-1:0] crc_i,
  input  byte_t           data_i,
  output logic [CrcW-1:0] crc_o
);

  always_comb begin
    logic [CrcW-1:0] c;
    c = crc_i ^ {{(CrcW-ByteW){1'b0}}, data_i};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

FILE: design/stuffed_frame_receiver_crc32_top.sv
// ----------------------------------------------------------------------------
// Stuffed frame receiver with CRC-32 check
// Removes byte stuffing from a flag-delimited link stream and checks the CRC.
// ----------------------------------------------------------------------------
// Usage: raw link bytes enter on the in channel (in_valid_i, in_ready_o,
// rx_byte_i), one transaction per byte. Each byte yields zero or one result
// on the out channel: a frame byte with its index, or an end of frame report
// with the stored length and a good flag. Marker and idle bytes give nothing.
// The frame_limit register is written through the cfg channel, which is
// always ready; write it only while the block is idle.
// A result appears on out_valid_o in the cycle after its byte is accepted.
// Throughput is one byte per cycle while the receiver takes results, set by
// the single byte-wide CRC and unstuffing stage feeding the result register.
// When the receiver stalls, the result register holds its transaction and
// in_ready_o stays high only while that register is empty or being emptied in the
// same cycle, so no result is lost or repeated.
// Reset puts the block in the idle state waiting for a flag, with
// frame_limit at 4096 and the result register empty.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_crc32_top import sfrc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic [ByteW-1:0]  out_byte_o,
  output logic [IndexW-1:0] out_index_o,
  output logic [CountW-1:0] frame_length_o,
  output logic              frame_good_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] frame_limit_i
);

`include "stuffed_frame_receiver_crc32_top_defines.svh"

  logic [CountW-1:0] limit_q;
  logic              in_frame_q, in_frame_d;
  logic              esc_q, esc_d;
  logic              ovf_q, ovf_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CrcW-1:0]   crc_q, crc_d, crc_next;
  byte_t             tail_q [TailLen];
  byte_t             tail_d [TailLen];

  logic              out_valid_q;
  logic              out_kind_q, out_kind_d;
  byte_t             out_byte_q, out_byte_d;
  logic [IndexW-1:0] out_index_q, out_index_d;
  logic [CountW-1:0] frame_length_q, frame_length_d;
  logic              frame_good_q, frame_good_d;

  logic              in_accept;
  logic              emit;
  logic              store_req;
  byte_t             store_val;
  logic [CountW-1:0] eff_limit;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign eff_limit   = (limit_q > MaxFrameBytes) ? MaxFrameBytes : limit_q;

  sfrc_crc_byte u_crc (
    .crc_i  (crc_q),
    .data_i (tail_q[TailLen-1]),
    .crc_o  (crc_next)
  );

  always_comb begin
    in_frame_d     = in_frame_q;
    esc_d          = esc_q;
    ovf_d          = ovf_q;
    cnt_d          = cnt_q;
    crc_d          = crc_q;
    tail_d         = tail_q;
    emit           = 1'b0;
    store_req      = 1'b0;
    store_val      = rx_byte_i;
    out_kind_d     = KindByte;
    out_byte_d     = '0;
    out_index_d    = '0;
    frame_length_d = '0;
    frame_good_d   = 1'b0;

    if (in_accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == FlagByte) begin
          in_frame_d = 1'b1;
          esc_d      = 1'b0;
          ovf_d      = 1'b0;
          cnt_d      = '0;
          crc_d      = CrcInit;
          for (int i = 0; i < TailLen; i++) begin
            tail_d[i] = '0;
          end
        end
      end else if (esc_q) begin
        esc_d     = 1'b0;
        store_req = 1'b1;
        store_val = rx_byte_i ^ EscXor;
      end else if (rx_byte_i == EscByte) begin
        esc_d = 1'b1;
      end else if (rx_byte_i == FlagByte) begin
        in_frame_d     = 1'b0;
        emit           = 1'b1;
        out_kind_d     = KindEnd;
        frame_length_d = cnt_q;
        frame_good_d   = !ovf_q && (cnt_q >= CrcLagBytes) &&
                         ((crc_q ^ CrcXorOut) ==
                          {tail_q[0], tail_q[1], tail_q[2], tail_q[3]});
      end else begin
        store_req = 1'b1;
      end
    end

    if (store_req && !ovf_q) begin
      if (cnt_q >= eff_limit) begin
        ovf_d = 1'b1;
      end else begin
        if (cnt_q >= CrcLagBytes) begin
          crc_d = crc_next;
        end
        for (int i = TailLen - 1; i > 0; i--) begin
          tail_d[i] = tail_q[i-1];
        end
        tail_d[0]   = store_val;
        cnt_d       = cnt_q + 1'b1;
        emit        = 1'b1;
        out_kind_d  = KindByte;
        out_byte_d  = store_val;
        out_index_d = cnt_q[IndexW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= frame_limit_i;
      end
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      ovf_q      <= ovf_d;
      cnt_q      <= cnt_d;
      crc_q      <= crc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
    if (emit) begin
      out_kind_q     <= out_kind_d;
      out_byte_q     <= out_byte_d;
      out_index_q    <= out_index_d;
      frame_length_q <= frame_length_d;
      frame_good_q   <= frame_good_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_byte_o     = out_byte_q;
  assign out_index_o    = out_index_q;
  assign frame_length_o = frame_length_q;
  assign frame_good_o   = frame_good_q;

  `SFRC_ASSERT_NOW(a_count_bounded, clk_i, rst_ni, 1'b1, cnt_q <= MaxFrameBytes)
  `SFRC_ASSERT_NOW(a_no_escape_idle, clk_i, rst_ni, !in_frame_q, !esc_q)
  `SFRC_ASSERT_NOW(a_byte_fields, clk_i, rst_ni, out_valid_q && out_kind_q == KindByte,
                   frame_length_q == '0 && !frame_good_q)
  `SFRC_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, emit, out_valid_q)

endmodule

FILE: sim/stuffed_frame_receiver_crc32_top_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the stuffed frame receiver with CRC-32 check
// Drives stuffed link bytes with random gaps and random output stalls. A
// deframing and CRC model predicts each byte result and end report, and the
// monitor compares them field by field. Several frame limits are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stuffed_frame_receiver_crc32_top_tb;
  import sfrc_pkg::*;

  typedef struct packed {
    logic              kind;
    byte_t             data;
    logic [IndexW-1:0] idx;
    logic [CountW-1:0] len;
    logic              good;
  } link_result_t;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned LongHold   = 120;
  localparam byte_t DirectedBytes[24] = '{
    8'h00, 8'hFF, 8'h7D, 8'h7E, 8'h00, 8'hFF, 8'h7D, 8'h5E, 8'h7D, 8'h7E, 8'h7D, 8'h5D,
    8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'hAA, 8'h7E, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E
  };

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  byte_t             rx_byte   = '0;
  logic              out_ready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CountW-1:0] frame_limit = '0;

  logic              in_ready_o;
  logic              out_valid_o;
  logic              out_kind_o;
  byte_t             out_byte_o;
  logic [IndexW-1:0] out_index_o;
  logic [CountW-1:0] frame_length_o;
  logic              frame_good_o;
  logic              cfg_ready_o;

  // Deframer model state.
  logic              rx_in_frame = 1'b0;
  logic              rx_escaped  = 1'b0;
  logic              rx_dropped  = 1'b0;
  logic [CountW-1:0] rx_count    = '0;
  logic [CrcW-1:0]   rx_crc      = CrcInit;
  byte_t             rx_tail[TailLen] = '{default: '0};
  logic [CountW-1:0] rx_limit    = LimitReset;

  byte_t        link_bytes[$];
  link_result_t expected_results[$];

  int unsigned bytes_queued  = 0;
  int unsigned bytes_taken   = 0;
  int unsigned frames_sent   = 0;
  int unsigned limits_used   = 0;
  int unsigned bytes_checked = 0;
  int unsigned reports_seen  = 0;
  int unsigned good_reports  = 0;
  int unsigned fail_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned send_gap      = 0;
  int unsigned stall_left    = 0;
  bit          no_gaps       = 1'b0;

  stuffed_frame_receiver_crc32_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .out_index_o    (out_index_o),
    .frame_length_o (frame_length_o),
    .frame_good_o   (frame_good_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .frame_limit_i  (frame_limit)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CrcW-1:0] crc32_byte(logic [CrcW-1:0] crc, byte_t b);
    int k;
    crc ^= {{(CrcW-ByteW){1'b0}}, b};
    for (k = 0; k < 8; k++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

  function automatic bit store_frame_byte(byte_t b, output link_result_t r);
    logic [CountW-1:0] lim;
    r = '0;
    lim = (rx_limit > MaxFrameBytes) ? MaxFrameBytes : rx_limit;
    if (rx_dropped) return 1'b0;
    if (rx_count >= lim) begin
      rx_dropped = 1'b1;
      return 1'b0;
    end
    if (rx_count >= CrcLagBytes) rx_crc = crc32_byte(rx_crc, rx_tail[3]);
    rx_tail[3] = rx_tail[2];
    rx_tail[2] = rx_tail[1];
    rx_tail[1] = rx_tail[0];
    rx_tail[0] = b;
    r.kind = KindByte;
    r.data = b;
    r.idx  = rx_count[IndexW-1:0];
    rx_count = rx_count + 1'b1;
    return 1'b1;
  endfunction

  function automatic bit deframe_step(byte_t b, output link_result_t r);
    r = '0;
    if (!rx_in_frame) begin
      if (b == FlagByte) begin
        rx_in_frame = 1'b1;
        rx_escaped  = 1'b0;
        rx_dropped  = 1'b0;
        rx_count    = '0;
        rx_crc      = CrcInit;
        rx_tail     = '{default: '0};
      end
      return 1'b0;
    end
    if (rx_escaped) begin
      rx_escaped = 1'b0;
      return store_frame_byte(b ^ EscXor, r);
    end
    if (b == EscByte) begin
      rx_escaped = 1'b1;
      return 1'b0;
    end
    if (b == FlagByte) begin
      rx_in_frame = 1'b0;
      r.kind = KindEnd;
      r.len  = rx_count;
      r.good = !rx_dropped && (rx_count >= CrcLagBytes) &&
               ({rx_tail[0], rx_tail[1], rx_tail[2], rx_tail[3]} == (rx_crc ^ CrcXorOut));
      return 1'b1;
    end
    return store_frame_byte(b, r);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic byte_t pick_byte(bit no_flag);
    byte_t b;
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 5))
        0:       b = FlagByte;
        1:       b = EscByte;
        2:       b = FlagByte ^ EscXor;
        3:       b = EscByte ^ EscXor;
        4:       b = 8'h00;
        default: b = 8'hFF;
      endcase
    end else begin
      b = byte_t'($urandom);
    end
    if (no_flag && b == FlagByte) b = 8'h00;
    return b;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Driver: presents queued link bytes and predicts results on acceptance.
  always @(posedge clk_i) begin : driver
    link_result_t res;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (deframe_step(rx_byte, res)) expected_results.push_back(res);
        bytes_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (link_bytes.size() > 0) begin
          in_valid <= 1'b1;
          rx_byte  <= link_bytes.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with random stalls and requested long hold-offs.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ready    <= 1'b0;
      hold_left    <= LongHold;
      holds_served <= holds_served + 1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk_i) begin : monitor
    link_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: kind %0d byte 0x%0h", out_kind_o, out_byte_o);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_kind", 32'(want.kind), 32'(out_kind_o));
        check_field("out_byte", 32'(want.data), 32'(out_byte_o));
        check_field("out_index", 32'(want.idx), 32'(out_index_o));
        check_field("frame_length", 32'(want.len), 32'(frame_length_o));
        check_field("frame_good", 32'(want.good), 32'(frame_good_o));
        if (want.kind == KindEnd) begin
          reports_seen++;
          if (want.good) good_reports++;
        end else begin
          bytes_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_raw(byte_t b);
    link_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic send_stuffed(byte_t b);
    if (b == FlagByte || b == EscByte || $urandom_range(0, 9) == 0) begin
      send_raw(EscByte);
      send_raw(b ^ EscXor);
    end else begin
      send_raw(b);
    end
  endtask

  task automatic send_frame(int unsigned len, bit corrupt, bit close);
    byte_t           body[$];
    logic [CrcW-1:0] crc;
    int unsigned     i;
    int unsigned     pos;
    crc = CrcInit;
    for (i = 0; i < len; i++) begin
      body.push_back(pick_byte(1'b0));
      crc = crc32_byte(crc, body[i]);
    end
    crc ^= CrcXorOut;
    for (i = 0; i < TailLen; i++) body.push_back(crc[8*i +: 8]);
    if (corrupt) begin
      pos = $urandom_range(0, body.size() - 1);
      body[pos] = body[pos] ^ byte_t'(1 << $urandom_range(0, 7));
    end
    send_raw(FlagByte);
    foreach (body[j]) send_stuffed(body[j]);
    if (close) send_raw(FlagByte);
    frames_sent++;
  endtask

  task automatic random_traffic(int unsigned n_bytes, int unsigned max_len);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    int unsigned i;
    byte_t       b;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, (max_len < 10) ? max_len : 10)
                                         : $urandom_range(0, max_len);
      if (r < 55) begin
        send_frame(len, 1'b0, 1'b1);
      end else if (r < 67) begin
        send_frame(len, 1'b1, 1'b1);
      end else if (r < 75) begin
        send_raw(FlagByte);
        repeat ($urandom_range(0, 3)) send_stuffed(pick_byte(1'b0));
        send_raw(FlagByte);
        frames_sent++;
      end else if (r < 83) begin
        repeat ($urandom_range(1, 4)) send_raw(pick_byte(1'b1));
      end else if (r < 90) begin
        // An escape just before the flag stores a byte and keeps the frame open.
        send_frame(len, 1'b0, 1'b0);
        send_raw(EscByte);
        send_raw(FlagByte);
        send_raw(FlagByte);
      end else if (r < 95) begin
        send_raw(FlagByte);
        for (i = 0; i < len + 1; i++) begin
          b = pick_byte(1'b1);
          if (i == len && b == EscByte) b = 8'h00;
          send_raw(b);
        end
        send_raw(FlagByte);
        frames_sent++;
      end else begin
        send_raw(FlagByte);
        send_raw(FlagByte);
        frames_sent++;
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (!(bytes_taken == bytes_queued && expected_results.size() == 0));
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CountW-1:0] value);
    @(posedge clk_i);
    cfg_valid   <= 1'b1;
    frame_limit <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    rx_limit = value;
    limits_used++;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedBytes[i]) send_raw(DirectedBytes[i]);
    drain();

    write_limit(13'd0);
    random_traffic(40, 6);
    drain();

    write_limit(13'd1);
    random_traffic(40, 6);
    drain();

    write_limit(13'd5);
    random_traffic(50, 4);
    drain();

    write_limit(13'h1FFF);
    random_traffic(30, 12);
    drain();

    write_limit(LimitReset);
    random_traffic(180, 40);
    drain();

    no_gaps = 1'b1;
    holds_asked++;
    random_traffic(40, 12);
    drain();
    no_gaps = 1'b0;

    write_limit(CountW'($urandom_range(0, MaxFrameBytes)));
    random_traffic(40, 20);
    drain();

    $display("Sent %0d link bytes in about %0d frames under %0d frame limit settings.",
             bytes_queued, frames_sent, limits_used);
    $display("Checked %0d frame bytes and %0d end reports, %0d of them good.",
             bytes_checked, reports_seen, good_reports);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
